@@ hdl/rtb_pkg.sv @@
// Shared types, operation codes and status codes for the reload timer bank.
`default_nettype none

package rtb_pkg;

    // Fixed field widths of the stream payloads.
    localparam int OP_W   = 3;
    localparam int NUM_W  = 5;
    localparam int REL_W  = 32;
    localparam int ID_W   = 5;
    localparam int STAT_W = 2;

    // Operation codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_REGISTER   = 3'd1,
        OP_UNREGISTER = 3'd2,
        OP_CHANGE     = 3'd3,
        OP_SET_STATE  = 3'd4
    } t_op;

    // Status codes of a reply.
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

    // Result kinds carried in the output tuser.
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LIST_RD,
        S_SLOT_RD,
        S_UPDATE,
        S_FLUSH,
        S_UNR_RD,
        S_UNR_CHK,
        S_UNR_END,
        S_SET_LOAD,
        S_REPLY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic do_register;
        logic do_change;
        logic set_enable;
        logic set_load;
        logic unreg_clear;
        logic clr_walk;
        logic load_k;
        logic advance;
        logic tick_upd;
        logic flush;
        logic unr_step;
        logic unr_end;
        logic send_reply;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;
        logic            full;
        logic            en_req;
        logic            list_empty;
        logic            last_entry;
        logic            slot_en;
        logic            zero_dec;
        logic            pend_valid;
        logic            out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/rtb_ctrl.sv @@
// Controller state machine that sequences each operation of the timer bank.
`default_nettype none

module rtb_ctrl
    import rtb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                unique case (i_stat.op)
                    OP_TICK: begin
                        o_cmd.clr_walk = 1'b1;
                        n_state = i_stat.list_empty ? S_IDLE : S_LIST_RD;
                    end
                    OP_REGISTER: begin
                        o_cmd.do_register = !i_stat.full;
                        n_state = S_REPLY;
                    end
                    OP_UNREGISTER: begin
                        if (i_stat.bad) begin
                            n_state = S_REPLY;
                        end else begin
                            o_cmd.unreg_clear = 1'b1;
                            o_cmd.clr_walk    = 1'b1;
                            n_state           = S_UNR_RD;
                        end
                    end
                    OP_CHANGE: begin
                        o_cmd.do_change = !i_stat.bad;
                        n_state = S_REPLY;
                    end
                    OP_SET_STATE: begin
                        o_cmd.set_enable = !i_stat.bad;
                        n_state = (!i_stat.bad && i_stat.en_req) ? S_SET_LOAD : S_REPLY;
                    end
                    default: begin
                        n_state = S_REPLY;
                    end
                endcase
            end
            S_LIST_RD: begin
                n_state = S_SLOT_RD;
            end
            S_SLOT_RD: begin
                o_cmd.load_k = 1'b1;
                if (i_stat.slot_en) begin
                    n_state = S_UPDATE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = i_stat.last_entry ? S_FLUSH : S_LIST_RD;
                end
            end
            S_UPDATE: begin
                // A new fire pushes the held one out, so it waits for a free output.
                if (!(i_stat.zero_dec && i_stat.pend_valid && !i_stat.out_free)) begin
                    o_cmd.tick_upd = 1'b1;
                    o_cmd.advance  = 1'b1;
                    n_state = i_stat.last_entry ? S_FLUSH : S_LIST_RD;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_UNR_RD: begin
                n_state = S_UNR_CHK;
            end
            S_UNR_CHK: begin
                o_cmd.unr_step = 1'b1;
                n_state = i_stat.last_entry ? S_UNR_END : S_UNR_RD;
            end
            S_UNR_END: begin
                o_cmd.unr_end = 1'b1;
                n_state       = S_REPLY;
            end
            S_SET_LOAD: begin
                o_cmd.set_load = 1'b1;
                n_state        = S_REPLY;
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.send_reply = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/rtb_dp.sv @@
// Datapath of the timer bank: slot storage, active list, walk index and output register.
`default_nettype none

module rtb_dp
    import rtb_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [OP_W-1:0]   i_in_op,
    input  logic [NUM_W-1:0]  i_in_num,
    input  logic [REL_W-1:0]  i_in_rel,
    input  logic              i_in_en,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_kind,
    output logic [ID_W-1:0]   o_out_id,
    output logic [STAT_W-1:0] o_out_status,
    output logic              o_out_last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    // Shifting by 64 gives zero, so the full-width case also ends as all ones.
    localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    // Captured transaction.
    logic [OP_W-1:0]  r_op;
    logic [NUM_W-1:0] r_num;
    logic [REL_W-1:0] r_rel;
    logic             r_en;
    logic [IDX_W-1:0] r_k;

    // Slot flags, active list and walk state.
    logic [NUM_TIMERS-1:0] r_in_use;
    logic [NUM_TIMERS-1:0] r_enabled;
    logic [CNT_W-1:0]      r_active_count;
    logic [IDX_W-1:0]      r_t;
    logic                  r_found;

    // Memories.
    logic [IDX_W-1:0]       r_list_mem   [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] r_count_mem  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] r_reload_mem [NUM_TIMERS];
    logic [IDX_W-1:0]       r_list_rdata;
    logic [COUNT_WIDTH-1:0] r_count_rdata;
    logic [COUNT_WIDTH-1:0] r_reload_rdata;

    // Reply, held fire event and output register.
    logic [ID_W-1:0]   r_rep_id;
    logic [STAT_W-1:0] r_rep_status;
    logic              r_pend_valid;
    logic [ID_W-1:0]   r_pend_id;
    logic              r_out_valid;
    logic              r_out_kind;
    logic [ID_W-1:0]   r_out_id;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_last;

    logic [6:0]             in_num_m1;
    logic [6:0]             num_m1;
    logic                   bad;
    logic [IDX_W-1:0]       free_idx;
    logic                   free_found;
    logic                   full;
    logic [63:0]            rel_ext;
    logic [63:0]            rel_sat;
    logic [COUNT_WIDTH-1:0] fit;
    logic [COUNT_WIDTH-1:0] dec;
    logic                   dec_zero;
    logic                   fire;
    logic                   push_fire;
    logic [IDX_W-1:0]       slot_raddr;
    logic                   list_we;
    logic [IDX_W-1:0]       list_waddr;
    logic [IDX_W-1:0]       list_wdata;
    logic                   count_we;
    logic [IDX_W-1:0]       count_waddr;
    logic [COUNT_WIDTH-1:0] count_wdata;
    logic                   reload_we;
    logic [IDX_W-1:0]       reload_waddr;
    logic [ID_W-1:0]        rep_id;
    logic [STAT_W-1:0]      rep_status;
    logic [CNT_W:0]         t_plus1;

    assign in_num_m1 = 7'(i_in_num) - 7'd1;
    assign num_m1    = 7'(r_num) - 7'd1;
    assign bad       = (r_num == '0) || (7'(r_num) > 7'(NUM_TIMERS))
                       || !r_in_use[IDX_W'(num_m1)];

    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign full = (r_active_count >= CNT_W'(NUM_TIMERS)) || !free_found;

    // Reload saturates to the counter range and a zero period becomes one tick.
    assign rel_ext = 64'(r_rel);
    assign rel_sat = (rel_ext > CNT_MAX) ? CNT_MAX : rel_ext;
    assign fit     = (rel_sat == 64'd0) ? COUNT_WIDTH'(1) : rel_sat[COUNT_WIDTH-1:0];

    assign dec       = r_count_rdata - COUNT_WIDTH'(1);
    assign dec_zero  = (dec == '0);
    assign fire      = i_cmd.tick_upd && dec_zero;
    assign push_fire = fire && r_pend_valid;

    assign t_plus1 = (CNT_W + 1)'(r_t) + (CNT_W + 1)'(1);

    always_comb begin
        rep_id     = '0;
        rep_status = STAT_OK;
        case (r_op) inside
            OP_TICK: begin
                rep_status = STAT_OK;
            end
            OP_REGISTER: begin
                rep_status = full ? STAT_FULL : STAT_OK;
                rep_id     = full ? '0 : ID_W'(7'(free_idx) + 7'd1);
            end
            OP_UNREGISTER, OP_CHANGE, OP_SET_STATE: begin
                rep_status = bad ? STAT_BAD : STAT_OK;
            end
            default: begin
                rep_status = STAT_BAD;
            end
        endcase
    end

    // Write ports of the memories.
    always_comb begin
        list_we    = 1'b0;
        list_waddr = IDX_W'(r_active_count);
        list_wdata = free_idx;
        if (i_cmd.do_register) begin
            list_we = 1'b1;
        end else if (i_cmd.unr_step && r_found) begin
            // Entries after the removed one move down by one place.
            list_we    = 1'b1;
            list_waddr = r_t - IDX_W'(1);
            list_wdata = r_list_rdata;
        end
    end

    always_comb begin
        count_we     = 1'b0;
        count_waddr  = r_k;
        count_wdata  = fit;
        reload_we    = 1'b0;
        reload_waddr = r_k;
        if (i_cmd.do_register) begin
            count_we     = 1'b1;
            count_waddr  = free_idx;
            reload_we    = 1'b1;
            reload_waddr = free_idx;
        end else if (i_cmd.do_change) begin
            count_we  = 1'b1;
            reload_we = 1'b1;
        end else if (i_cmd.set_load) begin
            count_we    = 1'b1;
            count_wdata = r_reload_rdata;
        end else if (i_cmd.tick_upd) begin
            count_we    = 1'b1;
            count_wdata = dec_zero ? r_reload_rdata : dec;
        end
    end

    assign slot_raddr = i_cmd.load_k ? r_list_rdata : r_k;

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            r_list_mem[list_waddr] <= list_wdata;
        end
        r_list_rdata <= r_list_mem[r_t];
    end

    always_ff @(posedge i_clk) begin
        if (count_we) begin
            r_count_mem[count_waddr] <= count_wdata;
        end
        r_count_rdata <= r_count_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (reload_we) begin
            r_reload_mem[reload_waddr] <= fit;
        end
        r_reload_rdata <= r_reload_mem[slot_raddr];
    end

    // Captured transaction and slot index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_op;
            r_num <= i_in_num;
            r_rel <= i_in_rel;
            r_en  <= i_in_en;
            r_k   <= IDX_W'(in_num_m1);
        end else if (i_cmd.load_k) begin
            r_k <= r_list_rdata;
        end
        if (i_cmd.decode) begin
            r_rep_id     <= rep_id;
            r_rep_status <= rep_status;
        end
        if (i_cmd.clr_walk) begin
            r_t <= '0;
        end else if (i_cmd.advance || i_cmd.unr_step) begin
            r_t <= r_t + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use       <= '0;
            r_enabled      <= '0;
            r_active_count <= '0;
            r_found        <= 1'b0;
        end else begin
            if (i_cmd.do_register) begin
                r_in_use[free_idx]  <= 1'b1;
                r_enabled[free_idx] <= 1'b1;
                r_active_count      <= r_active_count + CNT_W'(1);
            end
            if (i_cmd.unreg_clear) begin
                r_in_use[r_k]  <= 1'b0;
                r_enabled[r_k] <= 1'b0;
            end
            if (i_cmd.set_enable) begin
                r_enabled[r_k] <= r_en;
            end
            if (i_cmd.unr_end && r_found) begin
                r_active_count <= r_active_count - CNT_W'(1);
            end
            if (i_cmd.clr_walk) begin
                r_found <= 1'b0;
            end else if (i_cmd.unr_step && (r_list_rdata == r_k)) begin
                r_found <= 1'b1;
            end
        end
    end

    // The latest fire is held back until it is known whether another follows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.clr_walk) begin
            r_pend_valid <= 1'b0;
        end else if (fire) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pend_id <= ID_W'(7'(r_k) + 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_fire || i_cmd.flush || i_cmd.send_reply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire || i_cmd.flush) begin
            r_out_kind   <= KIND_FIRE;
            r_out_id     <= r_pend_id;
            r_out_status <= STAT_OK;
            r_out_last   <= i_cmd.flush;
        end else if (i_cmd.send_reply) begin
            r_out_kind   <= KIND_REPLY;
            r_out_id     <= r_rep_id;
            r_out_status <= r_rep_status;
            r_out_last   <= 1'b1;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.bad        = bad;
    assign o_stat.full       = full;
    assign o_stat.en_req     = r_en;
    assign o_stat.list_empty = (r_active_count == '0);
    assign o_stat.last_entry = (t_plus1 >= (CNT_W + 1)'(r_active_count));
    assign o_stat.slot_en    = r_enabled[r_list_rdata];
    assign o_stat.zero_dec   = dec_zero;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_id     = r_out_id;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

@@ hdl/reload_timer_bank.sv @@
// Top level of the reload timer bank: stream ports, controller and datapath.
`default_nettype none

// A bank of NUM_TIMERS auto-reload down-counters driven by one operation per input
// transaction (tick, register, unregister, change reload, set enable). A tick walks the
// active list in registration order: each enabled entry takes a list memory read, a slot
// memory read and a count update, and each disabled entry only the two reads. Capture
// and decode come before the walk and a flush step ends it; an empty list ends the tick
// at decode. Each fire event is one output transaction, the final one with tlast set,
// and there is no output if nothing fires. Set enable also reloads the count when it
// enables the timer. An unregister with an invalid number goes straight to its reply,
// and a valid one walks the list memory in order, moving later entries down one place.
// A stalled output holds the walk or the reply until the output is free.
// Every non-tick operation returns one status transaction with tlast set.
module reload_timer_bank
    import rtb_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // timer_number[4:0], reload_ticks[36:5], enable[37]
    input  logic [2:0]  s_axis_tuser,  // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // timer_id[4:0], status[6:5]
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast
);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [ID_W-1:0]   out_id;
    logic [STAT_W-1:0] out_status;

    rtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rtb_dp #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_op      (s_axis_tuser),
        .i_in_num     (s_axis_tdata[4:0]),
        .i_in_rel     (s_axis_tdata[36:5]),
        .i_in_en      (s_axis_tdata[37]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_kind   (m_axis_tuser),
        .o_out_id     (out_id),
        .o_out_status (out_status),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_status, out_id};

endmodule

`default_nettype wire

@@ sim/tb_reload_timer_bank.sv @@
// Self-checking testbench for the reload timer bank: stream driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_reload_timer_bank
    import rtb_pkg::*;
();

    localparam int TIMERS      = 16;
    localparam int CNT_W       = 32;
    localparam int LONG_STALL  = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 64;
    localparam int RANDOM_OPS  = 143;

    // Operation codes outside the defined set.
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    typedef enum int {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FULL_RATE} t_idle_phase;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [NUM_W-1:0] num;
        logic [REL_W-1:0] period;
        logic             en;
    } t_timer_cmd;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_bank_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // timer_number[4:0], reload_ticks[36:5], enable[37]
    logic [2:0]  s_axis_tuser = '0;  // op[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // timer_id[4:0], status[6:5]
    logic        m_axis_tuser;       // kind
    logic        m_axis_tlast;

    // Shadow of the timer bank.
    logic             tmr_in_use  [TIMERS];
    logic             tmr_enabled [TIMERS];
    logic [CNT_W-1:0] tmr_period  [TIMERS];
    logic [CNT_W-1:0] tmr_count   [TIMERS];
    logic [3:0]       reg_order   [TIMERS];
    int               reg_order_len;

    t_timer_cmd   pending_cmds[$];
    t_timer_cmd   cmd_on_bus;
    t_bank_result awaited_results[$];

    t_idle_phase idle_phase = PH_SLOW_SINK;
    int          tx_idle_pct = 22;
    int          rx_idle_pct = 81;
    int          stall_left = 0;
    bit          stall_done = 1'b0;
    int          quiet_cycles = 0;
    int          mismatches = 0;

    reload_timer_bank #(
        .NUM_TIMERS  (TIMERS),
        .COUNT_WIDTH (CNT_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [CNT_W-1:0] clamp_period(logic [REL_W-1:0] ticks);
        return (ticks == '0) ? CNT_W'(1) : CNT_W'(ticks);
    endfunction

    function automatic int find_timer(logic [NUM_W-1:0] num);
        if (num == 0 || num > TIMERS)
            return -1;
        if (!tmr_in_use[num - 1])
            return -1;
        return int'(num) - 1;
    endfunction

    function automatic t_bank_result status_reply(logic [ID_W-1:0] id, logic [STAT_W-1:0] st);
        t_bank_result r;
        r.kind   = KIND_REPLY;
        r.id     = id;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // Updates the shadow bank for one accepted command and queues the results it causes.
    task automatic apply_operation(t_timer_cmd cmd);
        int           fired[$];
        int           slot;
        int           pos;
        t_bank_result r;
        slot = -1;
        if (cmd.op == OP_TICK) begin
            for (int t = 0; t < reg_order_len; t++) begin
                slot = reg_order[t];
                if (tmr_enabled[slot]) begin
                    tmr_count[slot] = tmr_count[slot] - 1'b1;
                    if (tmr_count[slot] == '0) begin
                        fired.push_back(slot);
                        tmr_count[slot] = tmr_period[slot];
                    end
                end
            end
            foreach (fired[i]) begin
                r.kind   = KIND_FIRE;
                r.id     = ID_W'(fired[i] + 1);
                r.status = STAT_OK;
                r.last   = (i == fired.size() - 1);
                awaited_results.push_back(r);
            end
        end else begin
            case (cmd.op)
                OP_REGISTER: begin
                    if (reg_order_len >= TIMERS) begin
                        awaited_results.push_back(status_reply('0, STAT_FULL));
                    end else begin
                        for (int i = TIMERS - 1; i >= 0; i--)
                            if (!tmr_in_use[i])
                                slot = i;
                        tmr_in_use[slot]  = 1'b1;
                        tmr_enabled[slot] = 1'b1;
                        tmr_period[slot]  = clamp_period(cmd.period);
                        tmr_count[slot]   = tmr_period[slot];
                        reg_order[reg_order_len] = 4'(slot);
                        reg_order_len++;
                        awaited_results.push_back(status_reply(ID_W'(slot + 1), STAT_OK));
                    end
                end
                OP_UNREGISTER: begin
                    slot = find_timer(cmd.num);
                    if (slot < 0) begin
                        awaited_results.push_back(status_reply('0, STAT_BAD));
                    end else begin
                        tmr_in_use[slot]  = 1'b0;
                        tmr_enabled[slot] = 1'b0;
                        pos = reg_order_len;
                        for (int p = reg_order_len - 1; p >= 0; p--)
                            if (reg_order[p] == 4'(slot))
                                pos = p;
                        if (pos < reg_order_len) begin
                            for (int q = pos; q + 1 < reg_order_len; q++)
                                reg_order[q] = reg_order[q + 1];
                            reg_order_len--;
                        end
                        awaited_results.push_back(status_reply('0, STAT_OK));
                    end
                end
                OP_CHANGE: begin
                    slot = find_timer(cmd.num);
                    if (slot < 0) begin
                        awaited_results.push_back(status_reply('0, STAT_BAD));
                    end else begin
                        tmr_period[slot] = clamp_period(cmd.period);
                        tmr_count[slot]  = tmr_period[slot];
                        awaited_results.push_back(status_reply('0, STAT_OK));
                    end
                end
                OP_SET_STATE: begin
                    slot = find_timer(cmd.num);
                    if (slot < 0) begin
                        awaited_results.push_back(status_reply('0, STAT_BAD));
                    end else begin
                        tmr_enabled[slot] = cmd.en;
                        if (cmd.en)
                            tmr_count[slot] = tmr_period[slot];
                        awaited_results.push_back(status_reply('0, STAT_OK));
                    end
                end
                default: begin
                    awaited_results.push_back(status_reply('0, STAT_BAD));
                end
            endcase
        end
    endtask

    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    endtask

    task automatic queue_cmd(logic [OP_W-1:0] op, logic [NUM_W-1:0] num,
                             logic [REL_W-1:0] period, logic en);
        t_timer_cmd c;
        c.op     = op;
        c.num    = num;
        c.period = period;
        c.en     = en;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [OP_W-1:0] pick_reserved_op();
        return OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    endfunction

    task automatic queue_random_cmds(int count);
        logic [OP_W-1:0]  op;
        logic [NUM_W-1:0] num;
        logic [REL_W-1:0] period;
        int               r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 38)
                op = OP_TICK;
            else if (r < 58)
                op = OP_REGISTER;
            else if (r < 70)
                op = OP_UNREGISTER;
            else if (r < 82)
                op = OP_CHANGE;
            else if (r < 96)
                op = OP_SET_STATE;
            else
                op = pick_reserved_op();
            r = $urandom_range(99);
            if (r < 8)
                num = '0;
            else if (r < 14)
                num = NUM_W'($urandom_range(31, TIMERS + 1));
            else
                num = NUM_W'($urandom_range(TIMERS, 1));
            // Mostly short periods so that timers fire often; now and then a huge one.
            r = $urandom_range(99);
            if (r < 10)
                period = '0;
            else if (r < 20)
                period = $urandom;
            else
                period = REL_W'($urandom_range(6, 1));
            queue_cmd(op, num, period, 1'($urandom_range(1)));
        end
    endtask

    // Returns once every command has been taken and no result is awaited, plus a margin
    // long enough for a full tick walk that fires nothing.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                apply_operation(cmd_on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cmd_on_bus = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, cmd_on_bus.en, cmd_on_bus.period, cmd_on_bus.num};
                    s_axis_tuser  <= cmd_on_bus.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_bank_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[4:0] !== want.id)
                    report_mismatch("timer_id", m_axis_tdata[4:0], want.id);
                if (m_axis_tdata[6:5] !== want.status)
                    report_mismatch("status", m_axis_tdata[6:5], want.status);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
        // One long hold-off at the start of the full-rate phase lets the block back up.
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_phase == PH_FULL_RATE && !stall_done) begin
            stall_left = LONG_STALL;
            stall_done = 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < TIMERS; i++) begin
            tmr_in_use[i]  = 1'b0;
            tmr_enabled[i] = 1'b0;
        end
        reg_order_len = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(OP_TICK, '0, '0, 1'b0);
        queue_cmd(OP_UNREGISTER, '0, '0, 1'b0);
        queue_cmd(OP_REGISTER, '0, '0, 1'b0);               // zero period taken as one
        queue_cmd(OP_REGISTER, 5'd31, 32'hFFFF_FFFF, 1'b1);
        queue_cmd(OP_REGISTER, '0, 32'd2, 1'b0);
        queue_cmd(OP_REGISTER, '0, 32'd3, 1'b0);
        queue_cmd(OP_TICK, '0, '0, 1'b0);
        queue_cmd(OP_SET_STATE, 5'd3, '0, 1'b0);
        queue_cmd(OP_TICK, '0, '0, 1'b0);
        queue_cmd(OP_SET_STATE, 5'd3, '0, 1'b1);
        queue_cmd(OP_SET_STATE, 5'd31, '0, 1'b1);           // number above the bank
        queue_cmd(OP_CHANGE, 5'd1, 32'd5, 1'b0);
        queue_cmd(OP_CHANGE, 5'd16, 32'd5, 1'b0);           // slot not in use
        queue_cmd(OP_UNREGISTER, 5'd1, '0, 1'b0);
        queue_cmd(OP_UNREGISTER, 5'd1, '0, 1'b0);
        for (int i = 0; i < TIMERS - 3; i++)
            queue_cmd(OP_REGISTER, '0, 32'd1, 1'b0);
        queue_cmd(OP_REGISTER, '0, 32'd1, 1'b0);            // bank full
        queue_cmd(OP_TICK, '0, '0, 1'b0);
        queue_cmd(OP_RSVD_LO, 5'd16, 32'hFFFF_FFFF, 1'b1);
        queue_cmd(OP_RSVD_HI, 5'd2, '0, 1'b0);
        queue_random_cmds(RANDOM_OPS);
        wait_drained();

        idle_phase  = PH_SLOW_SOURCE;
        tx_idle_pct = 81;
        rx_idle_pct = 22;
        queue_random_cmds(RANDOM_OPS);
        wait_drained();

        idle_phase  = PH_FULL_RATE;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_cmds(RANDOM_OPS);
        wait_drained();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
